// ===== hw/rtl/pbae_pkg.sv =====
package pbae_pkg;

    localparam int EMF_W   = 24;
    localparam int CORD_W  = 27;
    localparam int PROD_W  = 43;
    localparam int TMP_W   = 28;

    localparam logic [15:0] CORDIC_GAIN_INV = 16'd39797;
    localparam logic [6:0]  WEAK_RATIO      = 7'd100;

    typedef logic signed [EMF_W-1:0]  emf_t;
    typedef logic signed [CORD_W-1:0] cord_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam logic [2:0] CFG_RES   = 3'd0;
    localparam logic [2:0] CFG_IND   = 3'd1;
    localparam logic [2:0] CFG_FILT  = 3'd2;
    localparam logic [2:0] CFG_SPEED = 3'd3;
    localparam logic [2:0] CFG_ANGLE = 3'd4;
    localparam logic [2:0] CFG_POS   = 3'd5;
    localparam logic [2:0] CFG_NEG   = 3'd6;
    localparam int         CFG_NUM   = 7;

    function automatic emf_t sat_emf(input prod_t v);
        prod_t hi;
        prod_t lo;
        hi = prod_t'((44'sd1 <<< (EMF_W - 1)) - 44'sd1);
        lo = -hi - prod_t'(1);
        if (v > hi) begin
            return emf_t'(hi);
        end else if (v < lo) begin
            return emf_t'(lo);
        end
        return emf_t'(v);
    endfunction

    function automatic logic signed [17:0] atan_turn(input logic [3:0] i);
        logic signed [17:0] r;
        unique case (i)
            4'd0: r = 18'sd8192;
            4'd1: r = 18'sd4836;
            4'd2: r = 18'sd2555;
            4'd3: r = 18'sd1297;
            4'd4: r = 18'sd651;
            4'd5: r = 18'sd326;
            4'd6: r = 18'sd163;
            4'd7: r = 18'sd81;
            4'd8: r = 18'sd41;
            4'd9: r = 18'sd20;
            4'd10: r = 18'sd10;
            4'd11: r = 18'sd5;
            4'd12: r = 18'sd3;
            4'd13: r = 18'sd1;
            4'd14: r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/pll_back_emf_angle_estimator_unit.sv =====
// channel | direction | beat contents
// s_      | in        | alpha/beta currents, alpha/beta voltages, bus voltage
// m_      | out       | estimated angle, raw angle, speed, goodness
// cfg_    | in        | register index and 16-bit data, always ready
// the shared 1-bit-per-cycle multiplier (ten products), the 16-step cordic and the
// 16-step divider set a sample's time; the divider is skipped when lock fails or the
// d magnitude is at least twice the q magnitude
// s_ready is high only while no sample is in work; a waiting result does not block it
// reset clears the fsm, filters, angle and cfg; a stalled result holds until taken
module pll_back_emf_angle_estimator_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_current_alpha,
    input  logic signed [15:0] s_current_beta,
    input  logic signed [15:0] s_voltage_alpha,
    input  logic signed [15:0] s_voltage_beta,
    input  logic [14:0]        s_bus_voltage,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_estimated_angle,
    output logic [15:0]        m_raw_angle_out,
    output logic signed [23:0] m_speed_estimate,
    output logic signed [15:0] m_goodness,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_addr,
    input  logic [15:0]        cfg_data
);
    import pbae_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOAD   = 4'd1;
    localparam logic [3:0] ST_MUL    = 4'd2;
    localparam logic [3:0] ST_POST   = 4'd3;
    localparam logic [3:0] ST_CINIT  = 4'd4;
    localparam logic [3:0] ST_CORDIC = 4'd5;
    localparam logic [3:0] ST_DIVI   = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    localparam logic [3:0] OP_RIA = 4'd0;
    localparam logic [3:0] OP_LIA = 4'd1;
    localparam logic [3:0] OP_RIB = 4'd2;
    localparam logic [3:0] OP_LIB = 4'd3;
    localparam logic [3:0] OP_GX  = 4'd4;
    localparam logic [3:0] OP_GY  = 4'd5;
    localparam logic [3:0] OP_FD  = 4'd6;
    localparam logic [3:0] OP_FQ  = 4'd7;
    localparam logic [3:0] OP_SPD = 4'd8;
    localparam logic [3:0] OP_ANG = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [3:0]  op_reg, op_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] cfg_reg [CFG_NUM];

    logic signed [15:0] ia_reg, ia_next, ib_reg, ib_next;
    logic signed [15:0] va_reg, va_next, vb_reg, vb_next;
    logic [14:0]        vbus_reg, vbus_next;
    logic signed [15:0] pa_reg, pa_next, pb_reg, pb_next;
    logic signed [TMP_W-1:0] tmp_reg, tmp_next;
    cord_t              x_reg, x_next, y_reg, y_next;
    logic signed [17:0] z_reg, z_next;
    emf_t               d_reg, d_next, q_reg, q_next;
    emf_t               fd_reg, fd_next, fq_reg, fq_next;
    emf_t               speed_reg, speed_next;
    logic [15:0]        raw_reg, raw_next;
    cord_t              ma_reg, ma_next;
    logic [15:0]        mb_reg, mb_next;
    prod_t              acc_reg, acc_next;
    logic [25:0]        rem_reg, rem_next;
    logic [15:0]        quo_reg, quo_next;
    logic [15:0]        good_reg, good_next;

    logic               m_valid_reg, m_valid_next;
    logic [15:0]        m_est_reg, m_est_next, m_raw_reg, m_raw_next;
    emf_t               m_speed_reg, m_speed_next;
    logic [15:0]        m_good_reg, m_good_next;

    cord_t              a_sel;
    logic [15:0]        b_sel;
    logic signed [24:0] adj;
    logic [23:0]        absd, absq;
    logic               lock_ok;
    logic signed [15:0] z16;
    cord_t              sx, sy;
    logic               ge;
    logic [15:0]        qf;
    logic               spd_pos;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_estimated_angle = m_est_reg;
    assign m_raw_angle_out   = m_raw_reg;
    assign m_speed_estimate  = m_speed_reg;
    assign m_goodness        = m_good_reg;

    always_comb begin
        adj = (fq_reg > 0) ? 25'(fq_reg) - 25'(fd_reg) : 25'(fq_reg) + 25'(fd_reg);
        unique case (op_reg)
            OP_RIA: begin a_sel = cord_t'(ia_reg); b_sel = cfg_reg[CFG_RES]; end
            OP_LIA: begin
                a_sel = cord_t'(17'(ia_reg) - 17'(pa_reg));
                b_sel = cfg_reg[CFG_IND];
            end
            OP_RIB: begin a_sel = cord_t'(ib_reg); b_sel = cfg_reg[CFG_RES]; end
            OP_LIB: begin
                a_sel = cord_t'(17'(ib_reg) - 17'(pb_reg));
                b_sel = cfg_reg[CFG_IND];
            end
            OP_GX: begin a_sel = x_reg; b_sel = CORDIC_GAIN_INV; end
            OP_GY: begin a_sel = y_reg; b_sel = CORDIC_GAIN_INV; end
            OP_FD: begin
                a_sel = cord_t'(25'(d_reg) - 25'(fd_reg));
                b_sel = cfg_reg[CFG_FILT];
            end
            OP_FQ: begin
                a_sel = cord_t'(25'(q_reg) - 25'(fq_reg));
                b_sel = cfg_reg[CFG_FILT];
            end
            OP_SPD: begin
                a_sel = cord_t'(adj);
                b_sel = cfg_reg[CFG_SPEED];
            end
            OP_ANG: begin a_sel = cord_t'(speed_reg); b_sel = cfg_reg[CFG_ANGLE]; end
            default: begin a_sel = '0; b_sel = '0; end
        endcase
    end

    always_comb begin
        absd    = fd_reg[23] ? 24'(-25'(fd_reg)) : 24'(fd_reg);
        absq    = fq_reg[23] ? 24'(-25'(fq_reg)) : 24'(fq_reg);
        lock_ok = (31'(absq) * 31'(WEAK_RATIO) > 31'(vbus_reg)) && (absq != '0);
        z16     = signed'(16'(16'd0 - raw_reg));
        sx      = x_reg >>> cnt_reg;
        sy      = y_reg >>> cnt_reg;
        ge      = rem_reg >= 26'(absq);
        qf      = {quo_reg[14:0], ge};
        spd_pos = !speed_reg[23] && (speed_reg != '0);
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        ia_next = ia_reg; ib_next = ib_reg; va_next = va_reg; vb_next = vb_reg;
        vbus_next = vbus_reg;
        pa_next = pa_reg; pb_next = pb_reg;
        tmp_next = tmp_reg;
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        d_next = d_reg; q_next = q_reg; fd_next = fd_reg; fq_next = fq_reg;
        speed_next = speed_reg;
        raw_next = raw_reg;
        ma_next = ma_reg; mb_next = mb_reg; acc_next = acc_reg;
        rem_next = rem_reg; quo_next = quo_reg; good_next = good_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_est_next = m_est_reg; m_raw_next = m_raw_reg;
        m_speed_next = m_speed_reg; m_good_next = m_good_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ia_next   = s_current_alpha;
                    ib_next   = s_current_beta;
                    va_next   = s_voltage_alpha;
                    vb_next   = s_voltage_beta;
                    vbus_next = s_bus_voltage;
                    op_next   = OP_RIA;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                ma_next  = a_sel;
                mb_next  = b_sel;
                acc_next = '0;
                cnt_next = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                acc_next = (acc_reg <<< 1) + (mb_reg[15] ? prod_t'(ma_reg) : prod_t'(0));
                mb_next  = {mb_reg[14:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                op_next    = op_reg + 4'd1;
                state_next = ST_LOAD;
                unique case (op_reg)
                    OP_RIA: tmp_next = TMP_W'(va_reg) - TMP_W'(acc_reg >>> 8);
                    OP_LIA: x_next = cord_t'(sat_emf(prod_t'(tmp_reg) - (acc_reg >>> 8)));
                    OP_RIB: tmp_next = TMP_W'(vb_reg) - TMP_W'(acc_reg >>> 8);
                    OP_LIB: begin
                        y_next = cord_t'(sat_emf(prod_t'(tmp_reg) - (acc_reg >>> 8)));
                        pa_next = ia_reg;
                        pb_next = ib_reg;
                        state_next = ST_CINIT;
                    end
                    OP_GX: d_next = sat_emf(acc_reg >>> 16);
                    OP_GY: q_next = sat_emf(acc_reg >>> 16);
                    OP_FD: fd_next = sat_emf(prod_t'(fd_reg) + (acc_reg >>> 16));
                    OP_FQ: fq_next = sat_emf(prod_t'(fq_reg) + (acc_reg >>> 16));
                    OP_SPD: speed_next = sat_emf(acc_reg >>> 8);
                    OP_ANG: begin
                        raw_next = raw_reg + acc_reg[31:16];
                        state_next = ST_DIVI;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_CINIT: begin
                cnt_next = '0;
                if (z16 >= 16'sd16384) begin
                    x_next = -x_reg;
                    y_next = -y_reg;
                    z_next = 18'(z16) - 18'sd32768;
                end else if (z16 < -16'sd16384) begin
                    x_next = -x_reg;
                    y_next = -y_reg;
                    z_next = 18'(z16) + 18'sd32768;
                end else begin
                    z_next = 18'(z16);
                end
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                if (!z_reg[17]) begin
                    x_next = x_reg - sy;
                    y_next = y_reg + sx;
                    z_next = z_reg - atan_turn(cnt_reg);
                end else begin
                    x_next = x_reg + sy;
                    y_next = y_reg - sx;
                    z_next = z_reg + atan_turn(cnt_reg);
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    op_next    = OP_GX;
                    state_next = ST_LOAD;
                end
            end
            ST_DIVI: begin
                cnt_next = '0;
                rem_next = 26'(absd);
                quo_next = '0;
                if (!lock_ok) begin
                    good_next  = '0;
                    state_next = ST_OUT;
                end else if (25'(absd) >= {absq, 1'b0}) begin
                    good_next  = 16'h8000;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = 26'((rem_reg - (ge ? 26'(absq) : 26'd0)) << 1);
                quo_next = qf;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    good_next  = (qf == '0) ? 16'h7fff : 16'(17'h08000 - 17'(qf));
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_est_next   = raw_reg + (spd_pos ? cfg_reg[CFG_POS] : cfg_reg[CFG_NEG]);
                    m_raw_next   = raw_reg;
                    m_speed_next = speed_reg;
                    m_good_next  = good_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_RIA;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            pa_reg <= '0; pb_reg <= '0;
            fd_reg <= '0; fq_reg <= '0;
            raw_reg <= '0;
            for (int i = 0; i < CFG_NUM; i++) begin
                cfg_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            pa_reg <= pa_next; pb_reg <= pb_next;
            fd_reg <= fd_next; fq_reg <= fq_next;
            raw_reg <= raw_next;
            if (cfg_valid && (int'(cfg_addr) < CFG_NUM)) begin
                cfg_reg[cfg_addr] <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ia_reg <= ia_next; ib_reg <= ib_next; va_reg <= va_next; vb_reg <= vb_next;
        vbus_reg <= vbus_next;
        tmp_reg <= tmp_next;
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        d_reg <= d_next; q_reg <= q_next;
        speed_reg <= speed_next;
        ma_reg <= ma_next; mb_reg <= mb_next; acc_reg <= acc_next;
        rem_reg <= rem_next; quo_reg <= quo_next; good_reg <= good_next;
        m_est_reg <= m_est_next; m_raw_reg <= m_raw_next;
        m_speed_reg <= m_speed_next; m_good_reg <= m_good_next;
    end

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a sample is in work");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_cordic_to_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORDIC && cnt_reg == 4'd15) |=>
            (state_reg == ST_LOAD && op_reg == OP_GX))
        else $error("cordic did not hand over to gain correction");

endmodule
